>>> hw/rtl/rau_pkg.sv
package rau_pkg;

  // Operation kinds carried in the input tuser field.
  localparam logic [2:0] K_MAKE = 3'd0;
  localparam logic [2:0] K_ADD  = 3'd1;
  localparam logic [2:0] K_SUB  = 3'd2;
  localparam logic [2:0] K_MUL  = 3'd3;
  localparam logic [2:0] K_DIV  = 3'd4;
  localparam logic [2:0] K_EQ   = 3'd5;
  localparam logic [2:0] K_LT   = 3'd6;
  localparam logic [2:0] K_GT   = 3'd7;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_LOAD_B,
    CMD_GCD_INIT,
    CMD_GCD_STEP,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_NORM,
    CMD_SAVE_A,
    CMD_SAVE_B,
    CMD_MUL1,
    CMD_MUL2,
    CMD_MUL3,
    CMD_COMB,
    CMD_OUT_ERR,
    CMD_OUT_CMP,
    CMD_OUT_RES
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_GCD_INIT,
    S_GCD,
    S_DIV_INIT,
    S_DIV,
    S_NORM,
    S_SAVE,
    S_LOAD_B,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_COMB,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_R
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       den_zero;
    logic       b_zero;
    logic       gcd_done;
    logic       div_done;
  } dp_status_t;

endpackage

>>> hw/rtl/rational_arithmetic_unit.sv
// Rational fraction unit. Each input word carries an operation kind in
// s_tuser and two signed fractions a and b in s_tdata. The unit reduces a
// and b (not for make), then returns the reduced a (make), the reduced sum,
// difference, product or quotient, or the outcome of an equal, less or
// greater compare. Exactly one output word is produced per input word,
// in order. A zero denominator, or a division by a zero fraction, gives
// status 1 in m_tuser with all other result fields zero.
// Every reduction runs a binary gcd (one shift or subtract per cycle) and
// then a shift-subtract divider that divides the numerator and the
// denominator by the gcd. A zero denominator is answered straight from
// the check, without any reduction.
// One word is in work at a time: s_tready is high only while the unit is
// idle, so the next word can be taken in the same cycle that m_tvalid rises.
// A finished word sits in the output register, so the next input word is
// taken while m_tvalid waits on a stalled receiver; the unit only holds at
// the end of that next word until the register is free.
// A synchronous reset returns the controller to idle and drops m_tvalid.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // a_num, a_den, b_num, b_den from bit 0 up, zero filled to whole bytes
  input  logic [((4*WIDTH+7)/8)*8-1:0] s_tdata,
  // kind
  input  logic [2:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // res_num (33), res_den (31), truth (1) from bit 0 up, zero filled
  output logic [71:0]         m_tdata,
  // status
  output logic [0:0]          m_tuser
);

  dp_status_t         sts;
  cmd_t               cmd;
  logic signed [32:0] res_num;
  logic [30:0]        res_den;
  logic               truth;
  logic               status;

  rau_control u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rau_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_kind  (s_tuser),
    .in_a_num (signed'(s_tdata[WIDTH-1:0])),
    .in_a_den (signed'(s_tdata[2*WIDTH-1:WIDTH])),
    .in_b_num (signed'(s_tdata[3*WIDTH-1:2*WIDTH])),
    .in_b_den (signed'(s_tdata[4*WIDTH-1:3*WIDTH])),
    .sts      (sts),
    .res_num  (res_num),
    .res_den  (res_den),
    .truth    (truth),
    .status   (status)
  );

  assign m_tdata = {7'b0, truth, res_den, res_num};
  assign m_tuser = status;

endmodule

>>> hw/rtl/rau_datapath.sv
module rau_datapath import rau_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic                    clk,
  input  cmd_t                    cmd,
  input  logic [2:0]              in_kind,
  input  logic signed [WIDTH-1:0] in_a_num,
  input  logic signed [WIDTH-1:0] in_a_den,
  input  logic signed [WIDTH-1:0] in_b_num,
  input  logic signed [WIDTH-1:0] in_b_den,
  output dp_status_t              sts,
  output logic signed [32:0]      res_num,
  output logic [30:0]             res_den,
  output logic                    truth,
  output logic                    status
);

  localparam int MW = 2 * WIDTH;     // magnitude width of any working value
  localparam int RW = MW + 1;        // signed working width
  localparam int AW = WIDTH + 1;     // signed width of a reduced operand
  localparam int CW = $clog2(MW + 1);

  logic [2:0]              kind;
  logic signed [WIDTH-1:0] ad_in, bn_in, bd_in;
  logic signed [AW-1:0]    a_n, a_d, b_n, b_d;
  logic signed [RW-1:0]    rn, rd, p1, p2, p3;
  logic [MW-1:0]           u, v, g, qn, qd, remn, remd;
  logic [CW-1:0]           k, cnt;

  logic [MW-1:0]           mag_n, mag_d;
  logic signed [AW-1:0]    mx, my;
  logic signed [2*AW-1:0]  prod;
  logic [MW:0]             tn, td;
  logic signed [63:0]      rn64, rd64;
  logic                    neg;

  assign mag_n = rn[RW-1] ? MW'(-rn) : MW'(rn);
  assign mag_d = rd[RW-1] ? MW'(-rd) : MW'(rd);
  assign tn    = {remn, qn[MW-1]};
  assign td    = {remd, qd[MW-1]};
  assign neg   = rn[RW-1] ^ rd[RW-1];
  assign rn64  = 64'(rn);
  assign rd64  = 64'(rd);

  // One shared multiplier; the operands follow the step and the kind.
  always_comb begin
    mx = a_n;
    my = b_d;
    case (cmd)
      CMD_MUL2: begin
        if (kind == K_MUL) begin
          mx = a_n;
          my = b_n;
        end else begin
          mx = b_n;
          my = a_d;
        end
      end
      CMD_MUL3: begin
        mx = a_d;
        my = (kind == K_DIV) ? b_n : b_d;
      end
      default: begin
        mx = a_n;
        my = b_d;
      end
    endcase
  end

  assign prod = mx * my;

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        kind  <= in_kind;
        ad_in <= in_a_den;
        bn_in <= in_b_num;
        bd_in <= in_b_den;
        rn    <= RW'(in_a_num);
        rd    <= RW'(in_a_den);
      end
      CMD_LOAD_B: begin
        rn <= RW'(bn_in);
        rd <= RW'(bd_in);
      end
      CMD_GCD_INIT: begin
        u <= mag_n;
        v <= mag_d;
        k <= '0;
      end
      CMD_GCD_STEP: begin
        // Binary gcd: strip common twos, then subtract the smaller odd value.
        if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u >= v) begin
          u <= u - v;
        end else begin
          v <= v - u;
        end
      end
      CMD_DIV_INIT: begin
        g    <= v << k;
        qn   <= mag_n;
        qd   <= mag_d;
        remn <= '0;
        remd <= '0;
        cnt  <= CW'(MW);
      end
      CMD_DIV_STEP: begin
        if (tn >= {1'b0, g}) begin
          remn <= MW'(tn - {1'b0, g});
          qn   <= {qn[MW-2:0], 1'b1};
        end else begin
          remn <= tn[MW-1:0];
          qn   <= {qn[MW-2:0], 1'b0};
        end
        if (td >= {1'b0, g}) begin
          remd <= MW'(td - {1'b0, g});
          qd   <= {qd[MW-2:0], 1'b1};
        end else begin
          remd <= td[MW-1:0];
          qd   <= {qd[MW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      CMD_NORM: begin
        rn <= neg ? -signed'({1'b0, qn}) : signed'({1'b0, qn});
        rd <= signed'({1'b0, qd});
      end
      CMD_SAVE_A: begin
        a_n <= signed'(rn[AW-1:0]);
        a_d <= signed'(rd[AW-1:0]);
      end
      CMD_SAVE_B: begin
        b_n <= signed'(rn[AW-1:0]);
        b_d <= signed'(rd[AW-1:0]);
      end
      CMD_MUL1: p1 <= RW'(prod);
      CMD_MUL2: p2 <= RW'(prod);
      CMD_MUL3: p3 <= RW'(prod);
      CMD_COMB: begin
        case (kind)
          K_ADD:   rn <= p1 + p2;
          K_SUB:   rn <= p1 - p2;
          K_MUL:   rn <= p2;
          default: rn <= p1;
        endcase
        rd <= p3;
      end
      CMD_OUT_ERR: begin
        res_num <= '0;
        res_den <= '0;
        truth   <= 1'b0;
        status  <= 1'b1;
      end
      CMD_OUT_CMP: begin
        res_num <= '0;
        res_den <= '0;
        status  <= 1'b0;
        case (kind)
          K_EQ:    truth <= (p1 == p2);
          K_LT:    truth <= (p1 < p2);
          default: truth <= (p1 > p2);
        endcase
      end
      CMD_OUT_RES: begin
        res_num <= rn64[32:0];
        res_den <= rd64[30:0];
        truth   <= 1'b0;
        status  <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign sts.kind     = kind;
  assign sts.den_zero = (ad_in == '0) || ((kind != K_MAKE) && (bd_in == '0));
  assign sts.b_zero   = (b_n == '0);
  assign sts.gcd_done = (u == '0);
  assign sts.div_done = (cnt == '0);

endmodule

>>> hw/rtl/rau_control.sv
module rau_control import rau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t sts,
  output cmd_t       cmd
);

  state_t state, state_next;
  phase_t phase, phase_next;
  cmd_t   out_cmd, out_cmd_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_A;
      out_cmd   <= CMD_OUT_ERR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      out_cmd   <= out_cmd_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    out_cmd_next   = out_cmd;
    out_valid_next = out_valid && !out_ready;
    cmd            = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          phase_next = PH_A;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.den_zero) begin
          out_cmd_next = CMD_OUT_ERR;
          state_next   = S_OUT;
        end else begin
          state_next = S_GCD_INIT;
        end
      end
      S_GCD_INIT: begin
        cmd        = CMD_GCD_INIT;
        state_next = S_GCD;
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          state_next = S_DIV_INIT;
        end else begin
          cmd = CMD_GCD_STEP;
        end
      end
      S_DIV_INIT: begin
        cmd        = CMD_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_NORM;
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_NORM: begin
        cmd = CMD_NORM;
        if (phase == PH_R || (phase == PH_A && sts.kind == K_MAKE)) begin
          out_cmd_next = CMD_OUT_RES;
          state_next   = S_OUT;
        end else begin
          state_next = S_SAVE;
        end
      end
      S_SAVE: begin
        if (phase == PH_A) begin
          cmd        = CMD_SAVE_A;
          state_next = S_LOAD_B;
        end else begin
          cmd        = CMD_SAVE_B;
          state_next = S_MUL1;
        end
      end
      S_LOAD_B: begin
        cmd        = CMD_LOAD_B;
        phase_next = PH_B;
        state_next = S_GCD_INIT;
      end
      S_MUL1: begin
        if (sts.kind == K_DIV && sts.b_zero) begin
          out_cmd_next = CMD_OUT_ERR;
          state_next   = S_OUT;
        end else begin
          cmd        = CMD_MUL1;
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd = CMD_MUL2;
        if (sts.kind inside {K_EQ, K_LT, K_GT}) begin
          out_cmd_next = CMD_OUT_CMP;
          state_next   = S_OUT;
        end else begin
          state_next = S_MUL3;
        end
      end
      S_MUL3: begin
        cmd        = CMD_MUL3;
        state_next = S_COMB;
      end
      S_COMB: begin
        cmd        = CMD_COMB;
        phase_next = PH_R;
        state_next = S_GCD_INIT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd            = out_cmd;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
